// File: sv/block_bitmap_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for block_bitmap_allocator_top
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

	// volume and bitmap geometry
	localparam int MAX_BLOCKS = 65536;
	localparam int BLK_W      = 16;
	localparam int CNT_W      = 17;
	localparam int VOL_W      = 17;
	localparam int BYTE_BITS  = 8;
	localparam int WORD_BITS  = 32;
	localparam int BIT_W      = 5;
	localparam int LANES      = WORD_BITS / BYTE_BITS;
	localparam int LANE_W     = 2;
	localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
	localparam int WADDR_W    = 11;
	localparam int BYTE_IDX_W = 13;

	// stream widths
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	// request codes
	typedef enum logic [1:0] {
		FUNC_USED  = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_ALLOC = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_PROC,
		ST_RESP
	} st_t;

	// per-request settings seen by the word unit
	typedef struct packed {
		func_t               func;
		logic [WADDR_W-1:0]  first_word;
		logic [WADDR_W-1:0]  last_word;
		logic [BIT_W-1:0]    first_bit;
		logic [BIT_W-1:0]    last_bit;
		logic [WADDR_W:0]    size_word;
		logic [BIT_W-1:0]    size_bit;
		logic [LANE_W-1:0]   start_lane;
		logic                first_visit;
	} scan_ctl_t;

	// word unit result
	typedef struct packed {
		logic [WORD_BITS-1:0] word_out;
		logic                 found;
		logic [BIT_W-1:0]     offset;
	} word_res_t;

endpackage

// File: sv/bba_word_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_word_unit
// Shared per-word unit: range mask for mark requests, free-bit search and
// bit set for allocate requests, on one 32-bit bitmap word.
// ----------------------------------------------------------------------------
module bba_word_unit import bba_pkg::*; (
	input  logic [WORD_BITS-1:0] word_in,
	input  logic [WADDR_W-1:0]   addr,
	input  scan_ctl_t            ctl,
	output word_res_t            res
);

	logic [BIT_W-1:0]     lo_bit;
	logic [BIT_W-1:0]     hi_bit;
	logic [WORD_BITS-1:0] range_mask;
	logic [WORD_BITS-1:0] vol_mask;
	logic [WORD_BITS-1:0] lane_mask;
	logic [WORD_BITS-1:0] view;
	logic [LANE_W-1:0]    lane_sel;
	logic [BYTE_BITS-1:0] sel_byte;
	logic [BIT_W-LANE_W-1:0] bit_sel;
	logic                 found;

	// range mask, partial only at the first and last word of the run
	always_comb begin
		lo_bit = (addr == ctl.first_word) ? ctl.first_bit : '0;
		hi_bit = (addr == ctl.last_word) ? ctl.last_bit : '1;
		range_mask = ({WORD_BITS{1'b1}} << lo_bit)
			& ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
	end

	// blocks past the volume end read as used
	always_comb begin
		if ({1'b0, addr} > ctl.size_word) begin
			vol_mask = '1;
		end else if ({1'b0, addr} == ctl.size_word) begin
			vol_mask = {WORD_BITS{1'b1}} << ctl.size_bit;
		end else begin
			vol_mask = '0;
		end
	end

	// bytes ahead of the start byte are skipped on the first visit
	always_comb begin
		lane_mask = '0;
		for (int l = 0; l < LANES; l++) begin
			if (ctl.first_visit && (LANE_W'(l) < ctl.start_lane)) begin
				lane_mask[l*BYTE_BITS +: BYTE_BITS] = '1;
			end
		end
	end

	// lowest byte not full, then its lowest clear bit
	always_comb begin
		view = word_in | vol_mask | lane_mask;
		found = 1'b0;
		lane_sel = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (view[l*BYTE_BITS +: BYTE_BITS] != {BYTE_BITS{1'b1}}) begin
				found = 1'b1;
				lane_sel = LANE_W'(l);
			end
		end
		sel_byte = view[lane_sel*BYTE_BITS +: BYTE_BITS];
		bit_sel = '0;
		for (int b = BYTE_BITS - 1; b >= 0; b--) begin
			if (!sel_byte[b]) begin
				bit_sel = (BIT_W-LANE_W)'(b);
			end
		end
	end

	// updated word
	always_comb begin
		res.found = found;
		res.offset = {lane_sel, bit_sel};
		case (ctl.func)
			FUNC_USED: res.word_out = word_in | range_mask;
			FUNC_FREE: res.word_out = word_in & ~range_mask;
			FUNC_ALLOC: res.word_out = word_in | (WORD_BITS'(1) << res.offset);
			default: res.word_out = word_in;
		endcase
	end

endmodule

// File: sv/block_bitmap_allocator_top.sv
`timescale 1ns / 1ps
`include "block_bitmap_allocator_top_macros.svh"
// ----------------------------------------------------------------------------
// block_bitmap_allocator_top
// Next-fit block allocator over a 65536-bit occupancy map.
// ----------------------------------------------------------------------------
// After reset the block clears every word of its occupancy map with
// s_axis_tready low; configuration writes are taken at any time. The map is
// a 2048 x 32 memory with one registered read and one write per cycle, and
// each request walks it one word at a time (read, then update and write). A
// mark request visits the words its range spans; an allocate visits at most
// ceil(size / 32) + 1 words, size being volume_blocks capped at 65536; and a
// zero count, an empty volume or an unused code goes straight to the response.
// One request is handled at a time; the result sits in an output register so
// the next request can start while it waits to be taken.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_top import bba_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// func [1:0], start_block [17:2], block_count [34:18], zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// allocated_block [15:0], status [16], zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [VOL_W-1:0]       cfg_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready
);

	st_t                  state_q, state_nxt;
	logic [WADDR_W-1:0]   w_q;
	logic [WADDR_W:0]     visit_q;
	logic [WADDR_W:0]     end_word_q;
	scan_ctl_t            ctl_q;
	logic [BLK_W-1:0]     last_granted_q;
	logic [VOL_W-1:0]     vol_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
	logic [BLK_W-1:0]     res_grant_q;
	logic                 res_status_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 mem_we;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 out_load;
	logic                 mark_done;
	logic                 scan_over;
	word_res_t            unit_res;

	// request fields
	func_t                in_func;
	logic [BLK_W-1:0]     in_start;
	logic [CNT_W-1:0]     in_count;

	// request setup
	logic [CNT_W:0]       stop_raw;
	logic [CNT_W:0]       stop_clip;
	logic [BLK_W-1:0]     last_blk;
	logic [VOL_W-1:0]     size_eff;
	logic [BYTE_IDX_W:0]  byte_limit;
	logic [BYTE_IDX_W-1:0] scan_byte;
	logic [WADDR_W:0]     end_word;
	logic [WADDR_W:0]     w_inc;

	assign in_func  = func_t'(s_axis_tdata[1:0]);
	assign in_start = s_axis_tdata[17:2];
	assign in_count = s_axis_tdata[34:18];
	assign accept   = s_axis_tvalid && s_axis_tready;

	// range end and search bounds from the request and the volume size
	always_comb begin
		stop_raw = (CNT_W+1)'(in_start) + (CNT_W+1)'(in_count);
		stop_clip = (stop_raw > (CNT_W+1)'(MAX_BLOCKS)) ? (CNT_W+1)'(MAX_BLOCKS) : stop_raw;
		last_blk = BLK_W'(stop_clip - (CNT_W+1)'(1));
		size_eff = (vol_q > VOL_W'(MAX_BLOCKS)) ? VOL_W'(MAX_BLOCKS) : vol_q;
		byte_limit = (BYTE_IDX_W+1)'(((VOL_W+1)'(size_eff) + (VOL_W+1)'(BYTE_BITS - 1)) >> 3);
		scan_byte = ({1'b0, last_granted_q[BLK_W-1:3]} >= byte_limit) ? '0
			: last_granted_q[BLK_W-1:3];
		end_word = (WADDR_W+1)'(((BYTE_IDX_W+2)'(byte_limit) + (BYTE_IDX_W+2)'(LANES - 1)) >> 2);
		w_inc = {1'b0, w_q} + (WADDR_W+1)'(1);
	end

	// shared word unit
	bba_word_unit u_word (
		.word_in (rdata_q),
		.addr    (w_q),
		.ctl     (ctl_q),
		.res     (unit_res)
	);

	assign mark_done = (w_q == ctl_q.last_word);
	assign scan_over = (visit_q == end_word_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (w_q == {WADDR_W{1'b1}}) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_func)
						FUNC_USED, FUNC_FREE:
							state_nxt = (in_count == '0) ? ST_RESP : ST_RD;
						FUNC_ALLOC:
							state_nxt = (size_eff == '0) ? ST_RESP : ST_RD;
						default: state_nxt = ST_RESP;
					endcase
				end
			end
			ST_RD: state_nxt = ST_PROC;
			ST_PROC: begin
				if (ctl_q.func == FUNC_ALLOC) begin
					state_nxt = (unit_res.found || scan_over) ? ST_RESP : ST_RD;
				end else begin
					state_nxt = mark_done ? ST_RESP : ST_RD;
				end
			end
			ST_RESP: begin
				if (!out_valid_q || m_axis_tready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we = 1'b0;
		mem_wdata = unit_res.word_out;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wdata = '0;
			end
			ST_IDLE: s_axis_tready = 1'b1;
			ST_PROC: begin
				mem_we = (ctl_q.func != FUNC_ALLOC) || unit_res.found;
			end
			ST_RESP: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	// occupancy map memory
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[w_q] <= mem_wdata;
		rdata_q <= mem_q[w_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			w_q <= '0;
			last_granted_q <= '0;
			vol_q <= VOL_W'(MAX_BLOCKS);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) vol_q <= cfg_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: w_q <= w_q + WADDR_W'(1);
				ST_IDLE: begin
					if (accept && in_func == FUNC_ALLOC) begin
						w_q <= scan_byte[BYTE_IDX_W-1:LANE_W];
					end else if (accept) begin
						w_q <= in_start[BLK_W-1:BIT_W];
					end
				end
				ST_PROC: begin
					if (ctl_q.func == FUNC_ALLOC && unit_res.found) begin
						last_granted_q <= {w_q, unit_res.offset};
					end else if (ctl_q.func == FUNC_ALLOC) begin
						w_q <= (w_inc == end_word_q) ? '0 : w_q + WADDR_W'(1);
					end else if (!mark_done) begin
						w_q <= w_q + WADDR_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// request settings, scan counters and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q.func <= in_func;
			ctl_q.first_word <= in_start[BLK_W-1:BIT_W];
			ctl_q.first_bit <= in_start[BIT_W-1:0];
			ctl_q.last_word <= last_blk[BLK_W-1:BIT_W];
			ctl_q.last_bit <= last_blk[BIT_W-1:0];
			ctl_q.size_word <= size_eff[VOL_W-1:BIT_W];
			ctl_q.size_bit <= size_eff[BIT_W-1:0];
			ctl_q.start_lane <= scan_byte[LANE_W-1:0];
			ctl_q.first_visit <= 1'b1;
			end_word_q <= end_word;
			visit_q <= '0;
			res_grant_q <= '0;
			res_status_q <= (in_func == FUNC_ALLOC) && (size_eff == '0);
		end else if (state_q == ST_PROC) begin
			ctl_q.first_visit <= 1'b0;
			visit_q <= visit_q + (WADDR_W+1)'(1);
			if (ctl_q.func == FUNC_ALLOC && unit_res.found) begin
				res_grant_q <= {w_q, unit_res.offset};
			end else if (ctl_q.func == FUNC_ALLOC && scan_over) begin
				res_status_q <= 1'b1;
			end
		end
		if (out_load) begin
			out_data_q <= {(OUT_TDATA_W-BLK_W-1)'(0), res_status_q, res_grant_q};
		end
	end

	assign m_axis_tdata  = out_data_q;
	assign m_axis_tvalid = out_valid_q;

	// checks
	`BBA_ASSERT_NXT(a_busy_after_accept, accept, !s_axis_tready,
		"request accepted while a previous one is in progress")
	`BBA_ASSERT_NXT(a_fail_keeps_grant,
		(state_q == ST_PROC) && (ctl_q.func == FUNC_ALLOC) && !unit_res.found,
		$stable(last_granted_q), "failed search step changed the last grant")
	`BBA_ASSERT_IMP(a_mark_in_range,
		(state_q == ST_PROC) && ((ctl_q.func == FUNC_USED) || (ctl_q.func == FUNC_FREE)),
		w_q <= ctl_q.last_word, "mark walk passed the last word of the run")
	`BBA_ASSERT_IMP(a_visit_bound,
		(state_q == ST_PROC) && (ctl_q.func == FUNC_ALLOC),
		visit_q <= end_word_q, "allocate search visited more words than a full circle")
	`BBA_ASSERT_IMP(a_fail_zero_grant, out_valid_q && out_data_q[BLK_W],
		out_data_q[BLK_W-1:0] == '0, "failed allocate reported a nonzero block")

endmodule
